### hw/rtl/cross_entropy_row_loss_top_macros.svh
// Assertion macros for the cross-entropy row loss checker
`ifndef CROSS_ENTROPY_ROW_LOSS_TOP_MACROS_SVH
`define CROSS_ENTROPY_ROW_LOSS_TOP_MACROS_SVH

// same-cycle implication
`define CERL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CERL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/cerl_pkg.sv
// Package: constants, state type and widths for the cross-entropy row loss block
package cerl_pkg;

   localparam int FRAC_BITS = 16;
   localparam int FIELD_W   = FRAC_BITS + 1;
   localparam int LOSS_W    = 32;
   localparam int LOG_FRAC  = 28;
   localparam int MANT_FRAC = 30;
   localparam int MANT_W    = MANT_FRAC + 1;
   localparam int SH_W      = $clog2(FRAC_BITS + 1);
   localparam int CNT_W     = $clog2(LOG_FRAC);
   localparam int T_W       = SH_W + LOG_FRAC;
   localparam int MUL_A_W   = T_W;
   localparam int MUL_B_W   = MANT_W;
   localparam int MUL_W     = MUL_A_W + MUL_B_W;
   localparam int LN_SHIFT  = LOG_FRAC + MANT_FRAC - FRAC_BITS;
   localparam int NL_W      = MUL_W - LN_SHIFT;

   localparam logic [MANT_FRAC-1:0] LN2_Q30 = 30'd744261118;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_SQUARE,
      ST_LNMUL,
      ST_TERM,
      ST_ACCUM
   } state_type;

endpackage

### hw/rtl/cross_entropy_row_loss_top.sv
// Flow: a taken request is normalized (one shift per leading zero of the clamped
//   probability below bit 16), its log2 mantissa squared 28 times in series on the
//   single shared multiplier, then scaled by ln2, weighted by the label and summed;
//   a new request is taken only once the sequencer is back in idle.
// Reset (synchronous, active high): accumulator and overflow flag cleared,
//   prob_floor back to one LSB (2^-16), sequencer idle, no result pending.
module cross_entropy_row_loss_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cerl_pkg::FIELD_W-1:0]  req_prob,
   input  logic [cerl_pkg::FIELD_W-1:0]  req_label,
   input  logic                          req_last_in_row,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cerl_pkg::LOSS_W-1:0]   rsp_loss,
   output logic                          rsp_saturated,
   input  logic                          csr_write_en,
   input  logic [cerl_pkg::FIELD_W-1:0]  csr_write_data
);
   import cerl_pkg::*;

   localparam logic [FIELD_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FIELD_W-1:0] LSB = FIELD_W'(1);

   state_type state_ff, state_in;

   logic [FIELD_W-1:0]  floor_ff, floor_in;
   logic [FIELD_W-1:0]  p_ff, p_in;
   logic [FIELD_W-1:0]  label_ff, label_in;
   logic                last_ff, last_in;
   logic [SH_W-1:0]     s_ff, s_in;
   logic [MANT_W-1:0]   m_ff, m_in;
   logic [LOG_FRAC-1:0] frac_ff, frac_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NL_W-1:0]     nl_ff, nl_in;
   logic [LOSS_W-1:0]   term_ff, term_in;
   logic [LOSS_W-1:0]   acc_ff, acc_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LOSS_W-1:0]   rsp_loss_ff, rsp_loss_in;
   logic                rsp_sat_ff, rsp_sat_in;

   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [MUL_W-1:0]    mul_p;
   logic [MANT_W:0]     sq;
   logic [T_W-1:0]      t_val;
   logic [FIELD_W-1:0]  floor_eff;
   logic [FIELD_W-1:0]  p_clamp;
   logic [LOSS_W:0]     sum;
   logic                req_take;
   logic                rsp_hold;

   assign req_take = req_valid && req_ready;
   assign rsp_hold = last_ff && rsp_valid_ff && !rsp_ready;

   assign floor_eff = (floor_ff == '0) ? LSB : floor_ff;
   always_comb begin
      p_clamp = (req_prob < floor_eff) ? floor_eff : req_prob;
      if (p_clamp > ONE) begin
         p_clamp = ONE;
      end
   end

   assign t_val = {s_ff, {LOG_FRAC{1'b0}}} - T_W'(frac_ff);
   assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
   assign sq    = mul_p[MANT_FRAC + MANT_W : MANT_FRAC];
   assign sum   = {1'b0, acc_ff} + {1'b0, term_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_take) state_in = ST_NORM;
         ST_NORM:   if (p_ff[FIELD_W-1]) state_in = ST_SQUARE;
         ST_SQUARE: if (cnt_ff == CNT_W'(LOG_FRAC - 1)) state_in = ST_LNMUL;
         ST_LNMUL:  state_in = ST_TERM;
         ST_TERM:   state_in = ST_ACCUM;
         ST_ACCUM:  if (!rsp_hold) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      floor_in     = csr_write_en ? csr_write_data : floor_ff;
      p_in         = p_ff;
      label_in     = label_ff;
      last_in      = last_ff;
      s_in         = s_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      nl_in        = nl_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_loss_in  = rsp_loss_ff;
      rsp_sat_in   = rsp_sat_ff;
      mul_a        = MUL_A_W'(m_ff);
      mul_b        = m_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               p_in     = p_clamp;
               label_in = req_label;
               last_in  = req_last_in_row;
               s_in     = '0;
            end
         end
         ST_NORM: begin
            if (p_ff[FIELD_W-1]) begin
               m_in    = {p_ff, {(MANT_FRAC - FRAC_BITS){1'b0}}};
               frac_in = '0;
               cnt_in  = '0;
            end else begin
               p_in = {p_ff[FIELD_W-2:0], 1'b0};
               s_in = s_ff + SH_W'(1);
            end
         end
         ST_SQUARE: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (sq[MANT_W]) begin
               m_in    = sq[MANT_W:1];
               frac_in = {frac_ff[LOG_FRAC-2:0], 1'b1};
            end else begin
               m_in    = sq[MANT_W-1:0];
               frac_in = {frac_ff[LOG_FRAC-2:0], 1'b0};
            end
         end
         ST_LNMUL: begin
            mul_a = t_val;
            mul_b = MUL_B_W'(LN2_Q30);
            nl_in = mul_p[MUL_W-1:LN_SHIFT] + NL_W'(mul_p[LN_SHIFT-1]);
         end
         ST_TERM: begin
            mul_a   = MUL_A_W'(nl_ff);
            mul_b   = MUL_B_W'(label_ff);
            term_in = mul_p[LOSS_W + FRAC_BITS - 1:FRAC_BITS]
                      + LOSS_W'(mul_p[FRAC_BITS-1]);
         end
         ST_ACCUM: begin
            if (!rsp_hold) begin
               acc_in = sum[LOSS_W] ? {LOSS_W{1'b1}} : sum[LOSS_W-1:0];
               ovf_in = ovf_ff || sum[LOSS_W];
               if (last_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_loss_in  = acc_in;
                  rsp_sat_in   = ovf_in;
                  acc_in       = '0;
                  ovf_in       = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         floor_ff     <= LSB;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         floor_ff     <= floor_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      label_ff    <= label_in;
      last_ff     <= last_in;
      s_ff        <= s_in;
      m_ff        <= m_in;
      frac_ff     <= frac_in;
      cnt_ff      <= cnt_in;
      nl_ff       <= nl_in;
      term_ff     <= term_in;
      rsp_loss_ff <= rsp_loss_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_loss      = rsp_loss_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

### hw/rtl/cerl_checker.sv
// Port-level checker for the cross-entropy row loss block, with its bind
`include "cross_entropy_row_loss_top_macros.svh"

module cerl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cerl_pkg::LOSS_W-1:0]   rsp_loss,
   input logic                          rsp_saturated
);
   import cerl_pkg::*;

   // a stalled result transaction holds
   `CERL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_loss) && $stable(rsp_saturated), "result changed while stalled")

   // busy once a request is taken
   `CERL_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready straight after request transaction")

   // a result never follows a request in the next cycle
   `CERL_ASSERT_NEXT(a_no_fast_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "result too soon after request")

   // reset leaves the block idle with nothing pending
   `CERL_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, req_ready && !rsp_valid, "not idle after reset")

endmodule

bind cross_entropy_row_loss_top cerl_checker u_cerl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_loss      (rsp_loss),
   .rsp_saturated (rsp_saturated)
);
